// File: rtl/core/tlac_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlac_pkg
// Shared sizes, codes and types for the two-level address binding cache.
// ----------------------------------------------------------------------------
package tlac_pkg;

  localparam int NEAR_WAYS   = 8;
  localparam int FAR_ENTRIES = 256;
  localparam int AGE_WIDTH   = 3;

  localparam int KEY_W  = 32;
  localparam int MAC_W  = 48;
  localparam int WAY_W  = $clog2(NEAR_WAYS);
  localparam int FAR_AW = $clog2(FAR_ENTRIES);
  localparam int FILL_W = FAR_AW + 1;

  localparam logic       OP_LOOKUP = 1'b0;
  localparam logic       OP_UPDATE = 1'b1;

  localparam logic [1:0] LVL_NONE = 2'd0;
  localparam logic [1:0] LVL_NEAR = 2'd1;
  localparam logic [1:0] LVL_FAR  = 2'd2;

  // One write or touch of a first-level way.
  typedef struct packed {
    logic             touch;
    logic             key_en;
    logic             mac_en;
    logic [WAY_W-1:0] way;
    logic [KEY_W-1:0] key;
    logic [MAC_W-1:0] mac;
  } near_cmd_t;

endpackage
`default_nettype wire

// File: rtl/core/tlac_near.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlac_near
// First-level ways: parallel key match, victim choice and age-based touch.
// ----------------------------------------------------------------------------
module tlac_near import tlac_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [KEY_W-1:0] key_i,
  output logic                  hit_o,
  output logic [WAY_W-1:0]      hit_way_o,
  output logic [WAY_W-1:0]      victim_way_o,
  output logic                  victim_valid_o,
  input  wire logic [WAY_W-1:0] rd_way_i,
  output logic [KEY_W-1:0]      rd_key_o,
  output logic [MAC_W-1:0]      rd_mac_o,
  input  wire near_cmd_t        cmd_i
);

  logic [KEY_W-1:0]     key_q   [NEAR_WAYS];
  logic [MAC_W-1:0]     mac_q   [NEAR_WAYS];
  logic [NEAR_WAYS-1:0] valid_q;
  logic [AGE_WIDTH-1:0] age_q   [NEAR_WAYS];
  logic [AGE_WIDTH-1:0] touch_age;

  // The lowest matching way wins.
  always_comb begin
    hit_o     = 1'b0;
    hit_way_o = '0;
    for (int i = NEAR_WAYS - 1; i >= 0; i--) begin
      if (valid_q[i] && key_q[i] == key_i) begin
        hit_o     = 1'b1;
        hit_way_o = WAY_W'(i);
      end
    end
  end

  // First invalid way, otherwise the last way holding the greatest age.
  always_comb begin
    logic                 found_free;
    logic [AGE_WIDTH-1:0] best;
    found_free   = 1'b0;
    best         = '0;
    victim_way_o = '0;
    for (int i = 0; i < NEAR_WAYS; i++) begin
      if (!found_free) begin
        if (!valid_q[i]) begin
          found_free   = 1'b1;
          victim_way_o = WAY_W'(i);
        end else if (age_q[i] >= best) begin
          best         = age_q[i];
          victim_way_o = WAY_W'(i);
        end
      end
    end
    victim_valid_o = !found_free;
  end

  assign rd_key_o  = key_q[rd_way_i];
  assign rd_mac_o  = mac_q[rd_way_i];
  assign touch_age = age_q[cmd_i.way];

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_en) begin
      key_q[cmd_i.way] <= cmd_i.key;
    end
    if (cmd_i.mac_en) begin
      mac_q[cmd_i.way] <= cmd_i.mac;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < NEAR_WAYS; i++) begin
        age_q[i] <= '0;
      end
    end else if (cmd_i.touch) begin
      if (cmd_i.key_en) begin
        valid_q[cmd_i.way] <= 1'b1;
      end
      for (int i = 0; i < NEAR_WAYS; i++) begin
        if (WAY_W'(i) == cmd_i.way) begin
          age_q[i] <= '0;
        end else if (age_q[i] <= touch_age) begin
          age_q[i] <= age_q[i] + AGE_WIDTH'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/two_level_arp_cache.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_level_arp_cache
// IPv4-to-MAC binding cache with a small associative first level and a
// large second-level table held in a synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
// An input word (op, ip, mac_in) is taken when in_valid_i is high and
// in_stall_o is low. A lookup (op 0) checks the first level; on a miss it
// reads the second-level memory one slot per cycle over its filled slots and
// promotes a hit into the first level. An update (op 1) refreshes a matching
// first-level way or inserts a new one. An evicted way is appended to the
// second level, or dropped when that table is full.
// Exactly one result word leaves per input word, through an output register
// with out_valid_o / out_stall_i. The block works on one word at a time:
// a first-level hit passes from S_NEAR to S_DONE and an update that misses
// goes through S_NEAR, S_INS and S_DONE; a lookup that misses the first level
// goes through S_NEAR, then S_SCAN for each second-level slot read, then
// S_INS if it promotes a hit, and S_DONE, so the sequential scan of the
// second-level memory dominates its time. Since second-level slots are only
// ever appended, a fill count marks the valid slots and the scan stops at it.
// A new word is accepted as soon as the previous one has moved into the
// output register, even while out_stall_i holds that result. Reset clears
// all first-level valid marks and ages and empties the second level at once.
// ----------------------------------------------------------------------------
module two_level_arp_cache import tlac_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             op_i,
  input  wire logic [KEY_W-1:0] ip_i,
  input  wire logic [MAC_W-1:0] mac_in_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [1:0]            hit_level_o,
  output logic [MAC_W-1:0]      mac_out_o,
  output logic                  victim_dropped_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NEAR = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]       state_q, state_d;
  logic             op_q, op_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [MAC_W-1:0] mac_q, mac_d;
  logic [FAR_AW-1:0] scan_q, scan_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [1:0]       res_lvl_q, res_lvl_d;
  logic [MAC_W-1:0] res_mac_q, res_mac_d;
  logic             res_drop_q, res_drop_d;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       out_lvl_q, out_lvl_d;
  logic [MAC_W-1:0] out_mac_q, out_mac_d;
  logic             out_drop_q, out_drop_d;

  // Second-level table: key in the upper bits, MAC in the lower bits.
  logic [KEY_W+MAC_W-1:0] far_mem [FAR_ENTRIES];
  logic [KEY_W+MAC_W-1:0] far_rdata_q;
  logic [KEY_W+MAC_W-1:0] far_wdata;
  logic                   far_we;
  logic [KEY_W-1:0]       far_rkey;
  logic [MAC_W-1:0]       far_rmac;

  logic             near_hit;
  logic [WAY_W-1:0] near_hit_way;
  logic [WAY_W-1:0] near_victim_way;
  logic             near_victim_valid;
  logic [WAY_W-1:0] near_rd_way;
  logic [KEY_W-1:0] near_rd_key;
  logic [MAC_W-1:0] near_rd_mac;
  near_cmd_t        near_cmd;

  logic out_free;
  logic far_full;
  logic scan_last;

  tlac_near u_near (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .key_i          (key_q),
    .hit_o          (near_hit),
    .hit_way_o      (near_hit_way),
    .victim_way_o   (near_victim_way),
    .victim_valid_o (near_victim_valid),
    .rd_way_i       (near_rd_way),
    .rd_key_o       (near_rd_key),
    .rd_mac_o       (near_rd_mac),
    .cmd_i          (near_cmd)
  );

  // During insertion the victim way is read so that it can move down.
  assign near_rd_way = (state_q == S_INS) ? near_victim_way : near_hit_way;

  assign far_rkey  = far_rdata_q[KEY_W+MAC_W-1:MAC_W];
  assign far_rmac  = far_rdata_q[MAC_W-1:0];
  assign far_full  = (fill_q == FILL_W'(FAR_ENTRIES));
  assign scan_last = (({1'b0, scan_q} + FILL_W'(1)) == fill_q);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign far_wdata = {near_rd_key, near_rd_mac};

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign hit_level_o      = out_lvl_q;
  assign mac_out_o        = out_mac_q;
  assign victim_dropped_o = out_drop_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    mac_d       = mac_q;
    scan_d      = scan_q;
    fill_d      = fill_q;
    res_lvl_d   = res_lvl_q;
    res_mac_d   = res_mac_q;
    res_drop_d  = res_drop_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_lvl_d   = out_lvl_q;
    out_mac_d   = out_mac_q;
    out_drop_d  = out_drop_q;
    far_we      = 1'b0;
    near_cmd    = '{touch: 1'b0, key_en: 1'b0, mac_en: 1'b0,
                    way: near_hit_way, key: key_q, mac: mac_q};

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = op_i;
          key_d   = ip_i;
          mac_d   = mac_in_i;
          state_d = S_NEAR;
        end
      end

      S_NEAR: begin
        res_drop_d = 1'b0;
        if (near_hit) begin
          near_cmd.touch  = 1'b1;
          near_cmd.mac_en = (op_q == OP_UPDATE);
          res_lvl_d       = LVL_NEAR;
          res_mac_d       = (op_q == OP_LOOKUP) ? near_rd_mac : '0;
          state_d         = S_DONE;
        end else if (op_q == OP_UPDATE) begin
          state_d = S_INS;
        end else if (fill_q == '0) begin
          res_lvl_d = LVL_NONE;
          res_mac_d = '0;
          state_d   = S_DONE;
        end else begin
          // Slot 0 is read at this edge and compared in the first scan cycle.
          scan_d  = '0;
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        if (far_rkey == key_q) begin
          mac_d   = far_rmac;
          state_d = S_INS;
        end else if (scan_last) begin
          res_lvl_d = LVL_NONE;
          res_mac_d = '0;
          state_d   = S_DONE;
        end else begin
          scan_d = scan_q + FAR_AW'(1);
        end
      end

      S_INS: begin
        near_cmd.touch  = 1'b1;
        near_cmd.key_en = 1'b1;
        near_cmd.mac_en = 1'b1;
        near_cmd.way    = near_victim_way;
        if (near_victim_valid) begin
          if (far_full) begin
            res_drop_d = 1'b1;
          end else begin
            far_we = 1'b1;
            fill_d = fill_q + FILL_W'(1);
          end
        end
        res_lvl_d = (op_q == OP_LOOKUP) ? LVL_FAR : LVL_NONE;
        res_mac_d = (op_q == OP_LOOKUP) ? mac_q : '0;
        state_d   = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_lvl_d   = res_lvl_q;
          out_mac_d   = res_mac_q;
          out_drop_d  = res_drop_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (far_we) begin
      far_mem[fill_q[FAR_AW-1:0]] <= far_wdata;
    end
    far_rdata_q <= far_mem[scan_d];
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    mac_q      <= mac_d;
    scan_q     <= scan_d;
    res_lvl_q  <= res_lvl_d;
    res_mac_q  <= res_mac_d;
    res_drop_q <= res_drop_d;
    out_lvl_q  <= out_lvl_d;
    out_mac_q  <= out_mac_d;
    out_drop_q <= out_drop_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire
